// ----- design/tcpct_pkg.sv -----
`default_nettype none

package tcpct_pkg;

  // Field widths of the request and result items.
  localparam int IDX_W = 10;
  localparam int IDX_MAX = 1023;
  localparam int TIME_W = 32;
  localparam int TO_W = 20;
  localparam int NUM_TIMEOUTS = 8;
  localparam int CFG_IDX_W = 3;

  // Default table size.
  localparam int ENTRIES_DFLT = 1024;

  // Connection states; the code doubles as the timeout register index.
  typedef enum logic [2:0] {
    ST_SYN_OUT     = 3'd0,
    ST_SYN_BACK    = 3'd1,
    ST_ESTABLISHED = 3'd2,
    ST_FIN_LOCAL   = 3'd3,
    ST_FIN_REMOTE  = 3'd4,
    ST_ACK_PENDING = 3'd5,
    ST_LINGER      = 3'd6,
    ST_CLOSE       = 3'd7
  } track_st_t;

  typedef logic [NUM_TIMEOUTS-1:0][TO_W-1:0] timeout_arr_t;

  // Reset values of the timeout registers, highest index first.
  localparam timeout_arr_t TIMEOUT_RST = {
    TO_W'(10),      // closed
    TO_W'(120),     // lingering after both FINs
    TO_W'(30),      // waiting for the final ACK
    TO_W'(60),      // reply side sent FIN
    TO_W'(120),     // originator sent FIN
    TO_W'(432000),  // established
    TO_W'(60),      // SYN answered
    TO_W'(120)      // SYN sent out
  };

  // One packet event.
  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic              entry_found;
    logic              from_reply;
    logic              flag_syn;
    logic              flag_ack;
    logic              flag_fin;
    logic              flag_rst;
    logic [TIME_W-1:0] now_seconds;
  } req_t;

  // One result: the slot contents after the update.
  typedef struct packed {
    logic              tracked;
    logic [2:0]        track_code;
    logic              unreplied;
    logic              assured;
    logic              conn_established;
    logic [TIME_W-1:0] expiry_deadline;
  } rsp_t;

  // One connection table slot.
  typedef struct packed {
    track_st_t         track;
    logic              conn_estab;
    logic              assured;
    logic              unreplied;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Write-back request from the update logic.
  typedef struct packed {
    logic   wr;
    entry_t entry;
  } upd_t;

endpackage

`default_nettype wire

// ----- design/tcpct_ram.sv -----
`default_nettype none

module tcpct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/tcpct_cfg.sv -----
`default_nettype none

module tcpct_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [tcpct_pkg::CFG_IDX_W-1:0] index,
  input  wire logic [tcpct_pkg::TO_W-1:0]     data,
  output tcpct_pkg::timeout_arr_t              timeouts
);

  import tcpct_pkg::*;

  // Timeout registers, one per connection state.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeouts <= TIMEOUT_RST;
    end else if (wr_en) begin
      timeouts[index] <= data;
    end
  end

endmodule

`default_nettype wire

// ----- design/tcpct_update.sv -----
`default_nettype none

module tcpct_update (
  input  wire tcpct_pkg::req_t         req,
  input  wire tcpct_pkg::entry_t       cur,
  input  wire tcpct_pkg::timeout_arr_t timeouts,
  output tcpct_pkg::upd_t              upd,
  output tcpct_pkg::rsp_t              rsp
);

  import tcpct_pkg::*;

  track_st_t ns;
  logic      touch;
  entry_t    nxt;

  // Next state of the slot for this packet.
  always_comb begin
    nxt   = cur;
    ns    = cur.track;
    touch = 1'b0;
    if (!req.entry_found) begin
      if (req.flag_syn) begin
        nxt.unreplied  = 1'b1;
        nxt.assured    = 1'b0;
        nxt.conn_estab = 1'b0;
        ns             = ST_SYN_OUT;
        touch          = 1'b1;
      end
    end else if (req.flag_rst) begin
      ns    = ST_CLOSE;
      touch = 1'b1;
    end else if (cur.track == ST_SYN_OUT && req.from_reply) begin
      // Only a SYN/ACK from the reply side moves on.
      if (req.flag_syn && req.flag_ack) begin
        nxt.unreplied  = 1'b0;
        nxt.conn_estab = 1'b1;
        ns             = ST_SYN_BACK;
        touch          = 1'b1;
      end
    end else if (cur.track == ST_SYN_BACK && !req.from_reply) begin
      // The originator's ACK completes the handshake.
      if (req.flag_ack) begin
        nxt.assured = 1'b1;
        ns          = ST_ESTABLISHED;
        touch       = 1'b1;
      end
    end else if (req.flag_fin) begin
      unique case (cur.track)
        ST_ESTABLISHED: begin
          ns    = req.from_reply ? ST_FIN_REMOTE : ST_FIN_LOCAL;
          touch = 1'b1;
        end
        ST_FIN_LOCAL: begin
          ns    = ST_LINGER;
          touch = 1'b1;
        end
        ST_FIN_REMOTE: begin
          ns    = ST_ACK_PENDING;
          touch = 1'b1;
        end
        default: begin
          touch = 1'b0;
        end
      endcase
    end else if ((cur.track == ST_ACK_PENDING || cur.track == ST_LINGER) && req.flag_ack) begin
      ns    = ST_CLOSE;
      touch = 1'b1;
    end else begin
      // Any other packet only refreshes the deadline.
      touch = 1'b1;
    end
    nxt.track = ns;
    if (touch) begin
      nxt.deadline = req.now_seconds + TIME_W'(timeouts[ns]);
    end
  end

  // Write-back and result.
  always_comb begin
    upd.wr    = touch;
    upd.entry = nxt;
    if (!req.entry_found && !req.flag_syn) begin
      rsp = '0;
    end else begin
      rsp.tracked          = 1'b1;
      rsp.track_code       = nxt.track;
      rsp.unreplied        = nxt.unreplied;
      rsp.assured          = nxt.assured;
      rsp.conn_established = nxt.conn_estab;
      rsp.expiry_deadline  = nxt.deadline;
    end
  end

endmodule

`default_nettype wire

// ----- design/tcp_conn_track_state_top.sv -----
`default_nettype none

// Channel   Handshake              Payload
// req       req_valid/req_ready    req_data  (one TCP packet event)
// rsp       rsp_valid/rsp_ready    rsp_data  (slot contents after the update)
// cfg       cfg_wr_en              cfg_index, cfg_data (timeout registers)
//
// One request is taken every cycle while req_ready is high; its result passes
// through the registered read of the slot memory and the result register. A
// request to the slot written in the same cycle gets the new contents through
// a bypass register. Reset loads the default timeouts and leaves the table
// contents undefined. A stalled result holds, the middle stage fills, and only
// then does req_ready drop.

module tcp_conn_track_state_top #(
  parameter int ENTRIES = tcpct_pkg::ENTRIES_DFLT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire tcpct_pkg::req_t                 req_data,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output tcpct_pkg::rsp_t                      rsp_data,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tcpct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcpct_pkg::TO_W-1:0]      cfg_data
);

  import tcpct_pkg::*;

  localparam int AW = $clog2(ENTRIES);

  timeout_arr_t     timeouts;
  logic [IDX_W-1:0] red;
  logic [AW-1:0]    slot_in;
  logic             accept;
  logic             advance;
  logic             wr_en;
  logic             stg_valid;
  req_t             stg_req;
  logic [AW-1:0]    stg_slot;
  logic             byp_hit;
  entry_t           byp_entry;
  logic [ENTRY_W-1:0] rd_data;
  entry_t           cur;
  upd_t             upd;
  rsp_t             rsp;

  // Slot index modulo the table size by compare and subtract.
  always_comb begin
    red = req_data.entry_index;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if ((ENTRIES << k) <= IDX_MAX) begin
        if (red >= IDX_W'(ENTRIES << k)) begin
          red = red - IDX_W'(ENTRIES << k);
        end
      end
    end
    slot_in = AW'(red);
  end

  // Handshake: the stage moves whenever the result register is free.
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !stg_valid || advance;
  assign accept    = req_valid && req_ready;
  assign wr_en     = stg_valid && advance && upd.wr;

  tcpct_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr_en),
    .index    (cfg_index),
    .data     (cfg_data),
    .timeouts (timeouts)
  );

  tcpct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stg_slot),
    .wr_data (upd.entry),
    .rd_en   (accept),
    .rd_addr (slot_in),
    .rd_data (rd_data)
  );

  // Stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      rsp_valid <= 1'b0;
      byp_hit   <= 1'b0;
    end else begin
      if (req_ready) begin
        stg_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= stg_valid;
      end
      if (accept) begin
        byp_hit <= wr_en && (stg_slot == slot_in);
      end
    end
  end

  // Stage and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_req   <= req_data;
      stg_slot  <= slot_in;
      byp_entry <= upd.entry;
    end
    if (advance && stg_valid) begin
      rsp_data <= rsp;
    end
  end

  // Slot contents, taking the same-cycle write when the slots match.
  assign cur = byp_hit ? byp_entry : entry_t'(rd_data);

  tcpct_update u_update (
    .req      (stg_req),
    .cur      (cur),
    .timeouts (timeouts),
    .upd      (upd),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
